/* sv/rth_pkg.sv */
package rth_pkg;

    localparam int MAX_RECTS  = 32;
    localparam int PIXEL_BITS = 12;
    localparam int FRAC_BITS  = 12;

    // fixed field widths
    localparam int Q_W       = 16;
    localparam int REL_W     = 12;
    localparam int IDX_OUT_W = 5;
    localparam int STATUS_W  = 2;
    localparam int MODE_W    = 1;

    localparam int IDX_W   = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNT_W   = $clog2(MAX_RECTS + 1);
    localparam int ENTRY_W = 4 * Q_W;

    // scaled point, relative dividend, shared divider width
    localparam int FX_W      = PIXEL_BITS + FRAC_BITS;
    localparam int REL_DVD_W = Q_W + FRAC_BITS;
    localparam int DVD_W     = (FX_W > REL_DVD_W) ? FX_W : REL_DVD_W;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);
    localparam int CMP_W     = (FX_W > Q_W + 1) ? FX_W : Q_W + 1;

    // stream packing
    localparam int S_PX_LSB    = 0;
    localparam int S_PY_LSB    = S_PX_LSB + PIXEL_BITS;
    localparam int S_LEFT_LSB  = S_PY_LSB + PIXEL_BITS;
    localparam int S_TOP_LSB   = S_LEFT_LSB + Q_W;
    localparam int S_WIDTH_LSB = S_TOP_LSB + Q_W;
    localparam int S_HGT_LSB   = S_WIDTH_LSB + Q_W;
    localparam int S_TDATA_W   = ((S_HGT_LSB + Q_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((IDX_OUT_W + 2 * REL_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_ADDR_W = CFG_IDX_W + 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = 1'd1;

    localparam logic [MODE_W-1:0] MODE_ADD   = 1'b0;
    localparam logic [MODE_W-1:0] MODE_QUERY = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED = 2'd0,
        ST_FULL  = 2'd1,
        ST_HIT   = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [Q_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

/* sv/rth_ram.sv */
module rth_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

/* sv/rth_div.sv */
// Restoring divider, one quotient bit per cycle, MSB first.
module rth_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  rth_pkg::div_req_t  req,
    output rth_pkg::div_rsp_t  rsp
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [rth_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [rth_pkg::Q_W-1:0]        rem_reg, rem_next;
    logic [rth_pkg::DVD_W-1:0]      dvd_reg, dvd_next;
    logic [rth_pkg::Q_W-1:0]        dsr_reg, dsr_next;

    logic [rth_pkg::Q_W:0]          rem_sh;
    logic [rth_pkg::Q_W:0]          rem_sub;
    logic                           ge;

    always_comb begin
        rem_sh  = {rem_reg, dvd_reg[rth_pkg::DVD_W-1]};
        ge      = rem_sh >= {1'b0, dsr_reg};
        rem_sub = rem_sh - {1'b0, dsr_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;

        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = rth_pkg::DIV_CNT_W'(rth_pkg::DVD_W);
            rem_next  = '0;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so Q_W bits hold it
            rem_next = ge ? rem_sub[rth_pkg::Q_W-1:0] : rem_sh[rth_pkg::Q_W-1:0];
            dvd_next = {dvd_reg[rth_pkg::DVD_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == rth_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

/* sv/rect_table_hit_test.sv */
// Rectangle table with point hit test.
// Input beats (s_*): tuser = mode. An add beat appends a Q4.12 rectangle to a
// table of up to 32 entries; a query beat carries a pixel coordinate, which is
// rotated for a portrait viewport, scaled to Q12.12 by the short side and then
// matched against the table in insertion order.
// Result beats (m_*): one per input beat; tuser = status (added, full, hit,
// miss), tdata = hit index and Q0.12 position inside the hit rectangle.
// view_width / view_height are to be written over the APB port only while
// idle; the block does not enforce this. Throughput: one beat at a time;
// s_tready is high only while idle. An add or early miss goes from accept
// through S_OUT to the output register. A query divides x, then y, to scale
// the point, scans the stored rectangles and, on a hit, divides twice more
// for the relative position. The single serial divider (one quotient bit per
// cycle, 28 bits) and the one table read port set the pace of a query.
// A finished result waits in the output register while m_tready is low; the
// block takes the next beat meanwhile and holds its result until the
// register frees up.
// Reset empties the table (count to zero; entries stay unwritten) and sets
// both viewport registers to 1.
module rect_table_hit_test (
    input  logic                               aclk,
    input  logic                               aresetn,
    // APB configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rth_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [rth_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [rth_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // point_x, point_y, rect_left, rect_top, rect_width, rect_height
    input  logic [rth_pkg::S_TDATA_W-1:0]      s_tdata,
    // mode
    input  logic [rth_pkg::MODE_W-1:0]         s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // hit_index, rel_x, rel_y, zero pad
    output logic [rth_pkg::M_TDATA_W-1:0]      m_tdata,
    // status
    output logic [rth_pkg::STATUS_W-1:0]       m_tuser
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIVX = 7'b0000010,
        S_DIVY = 7'b0000100,
        S_SCAN = 7'b0001000,
        S_RELX = 7'b0010000,
        S_RELY = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    localparam int PB = rth_pkg::PIXEL_BITS;
    localparam int QW = rth_pkg::Q_W;

    state_t                          state_reg, state_next;
    logic [rth_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [PB-1:0]                   vw_reg, vw_next;
    logic [PB-1:0]                   vh_reg, vh_next;
    logic [rth_pkg::CNT_W-1:0]       scan_idx_reg, scan_idx_next;
    logic                            cmp_vld_reg, cmp_vld_next;
    logic                            m_tvalid_reg, m_tvalid_next;

    logic [rth_pkg::IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [rth_pkg::FX_W-1:0]        fx_reg, fx_next;
    logic [rth_pkg::FX_W-1:0]        fy_reg, fy_next;
    logic [PB-1:0]                   qy_reg, qy_next;
    logic [PB-1:0]                   r_reg, r_next;
    logic [QW-1:0]                   dy_reg, dy_next;
    logic [QW-1:0]                   h_reg, h_next;
    logic [rth_pkg::IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    logic [rth_pkg::REL_W-1:0]       rel_x_reg, rel_x_next;
    logic [rth_pkg::REL_W-1:0]       rel_y_reg, rel_y_next;
    rth_pkg::status_t                res_status_reg, res_status_next;
    rth_pkg::status_t                m_status_reg, m_status_next;
    logic [rth_pkg::IDX_OUT_W-1:0]   m_idx_reg, m_idx_next;
    logic [rth_pkg::REL_W-1:0]       m_rel_x_reg, m_rel_x_next;
    logic [rth_pkg::REL_W-1:0]       m_rel_y_reg, m_rel_y_next;

    rth_pkg::div_req_t               div_req;
    rth_pkg::div_rsp_t               div_rsp;

    logic                            ram_wr_en;
    logic                            ram_rd_en;
    logic [rth_pkg::ENTRY_W-1:0]     ram_rd_data;

    logic                            s_accept;
    logic                            cfg_wr;
    logic [rth_pkg::CFG_IDX_W-1:0]   cfg_idx;

    logic [PB-1:0]                   in_px, in_py;
    logic [QW-1:0]                   in_left, in_top, in_width, in_height;
    logic                            portrait;
    logic [PB-1:0]                   rot_qx, rot_qy, rot_r;
    logic                            rot_miss;

    logic [QW-1:0]                   e_left, e_top, e_width, e_height;
    logic [rth_pkg::CMP_W-1:0]       fx_c, fy_c, dx_c, dy_c;
    logic                            in_x, in_y, entry_hit;

    // ---------------------------------------------------------------
    // input fields
    assign in_px     = s_tdata[rth_pkg::S_PX_LSB +: PB];
    assign in_py     = s_tdata[rth_pkg::S_PY_LSB +: PB];
    assign in_left   = s_tdata[rth_pkg::S_LEFT_LSB +: QW];
    assign in_top    = s_tdata[rth_pkg::S_TOP_LSB +: QW];
    assign in_width  = s_tdata[rth_pkg::S_WIDTH_LSB +: QW];
    assign in_height = s_tdata[rth_pkg::S_HGT_LSB +: QW];

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // portrait: x' = y, y' = width - x, short side is the width
    assign portrait = vh_reg > vw_reg;
    assign rot_qx   = portrait ? in_py : in_px;
    assign rot_qy   = portrait ? (vw_reg - in_px) : in_py;
    assign rot_r    = portrait ? vw_reg : vh_reg;
    assign rot_miss = (portrait && (in_px > vw_reg)) || (rot_r == '0);

    // table entry under compare
    assign e_left   = ram_rd_data[0 +: QW];
    assign e_top    = ram_rd_data[QW +: QW];
    assign e_width  = ram_rd_data[2*QW +: QW];
    assign e_height = ram_rd_data[3*QW +: QW];

    assign fx_c = rth_pkg::CMP_W'(fx_reg);
    assign fy_c = rth_pkg::CMP_W'(fy_reg);
    assign dx_c = fx_c - rth_pkg::CMP_W'(e_left);
    assign dy_c = fy_c - rth_pkg::CMP_W'(e_top);

    // half-open on each side
    assign in_x = (fx_c >= rth_pkg::CMP_W'(e_left)) &&
                  (fx_c < rth_pkg::CMP_W'(e_left) + rth_pkg::CMP_W'(e_width));
    assign in_y = (fy_c >= rth_pkg::CMP_W'(e_top)) &&
                  (fy_c < rth_pkg::CMP_W'(e_top) + rth_pkg::CMP_W'(e_height));
    assign entry_hit = (e_width != '0) && (e_height != '0) && in_x && in_y;

    assign ram_wr_en = s_accept && (s_tuser == rth_pkg::MODE_ADD) &&
                       (count_reg < rth_pkg::CNT_W'(rth_pkg::MAX_RECTS));
    assign ram_rd_en = (state_reg == S_SCAN) && (scan_idx_reg < count_reg);

    // ---------------------------------------------------------------
    // configuration
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[rth_pkg::CFG_ADDR_W-1:2];

    always_comb begin
        unique case (cfg_idx)
            rth_pkg::REG_VIEW_WIDTH:  prdata = rth_pkg::CFG_DATA_W'(vw_reg);
            rth_pkg::REG_VIEW_HEIGHT: prdata = rth_pkg::CFG_DATA_W'(vh_reg);
            default:                  prdata = '0;
        endcase
    end

    always_comb begin
        vw_next = vw_reg;
        vh_next = vh_reg;
        if (cfg_wr) begin
            unique case (cfg_idx)
                rth_pkg::REG_VIEW_WIDTH:  vw_next = pwdata[PB-1:0];
                rth_pkg::REG_VIEW_HEIGHT: vh_next = pwdata[PB-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // sequencer
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        fx_next         = fx_reg;
        fy_next         = fy_reg;
        qy_next         = qy_reg;
        r_next          = r_reg;
        dy_next         = dy_reg;
        h_next          = h_reg;
        hit_idx_next    = hit_idx_reg;
        rel_x_next      = rel_x_reg;
        rel_y_next      = rel_y_reg;
        res_status_next = res_status_reg;

        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_idx_next      = m_idx_reg;
        m_rel_x_next    = m_rel_x_reg;
        m_rel_y_next    = m_rel_y_reg;

        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_OUT;
                    if (s_tuser == rth_pkg::MODE_ADD) begin
                        if (ram_wr_en) begin
                            count_next      = count_reg + 1'b1;
                            res_status_next = rth_pkg::ST_ADDED;
                        end else begin
                            res_status_next = rth_pkg::ST_FULL;
                        end
                    end else if (rot_miss) begin
                        res_status_next = rth_pkg::ST_MISS;
                    end else begin
                        qy_next          = rot_qy;
                        r_next           = rot_r;
                        div_req.start    = 1'b1;
                        div_req.dividend =
                            rth_pkg::DVD_W'({rot_qx, {rth_pkg::FRAC_BITS{1'b0}}});
                        div_req.divisor  = QW'(rot_r);
                        state_next       = S_DIVX;
                    end
                end
            end
            S_DIVX: begin
                if (div_rsp.done) begin
                    fx_next          = div_rsp.quotient[rth_pkg::FX_W-1:0];
                    div_req.start    = 1'b1;
                    div_req.dividend =
                        rth_pkg::DVD_W'({qy_reg, {rth_pkg::FRAC_BITS{1'b0}}});
                    div_req.divisor  = QW'(r_reg);
                    state_next       = S_DIVY;
                end
            end
            S_DIVY: begin
                if (div_rsp.done) begin
                    fy_next       = div_rsp.quotient[rth_pkg::FX_W-1:0];
                    scan_idx_next = '0;
                    cmp_vld_next  = 1'b0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN: begin
                // read of entry i overlaps the compare of entry i-1
                if (cmp_vld_reg && entry_hit) begin
                    hit_idx_next     = cmp_idx_reg;
                    dy_next          = dy_c[QW-1:0];
                    h_next           = e_height;
                    div_req.start    = 1'b1;
                    div_req.dividend =
                        rth_pkg::DVD_W'({dx_c[QW-1:0], {rth_pkg::FRAC_BITS{1'b0}}});
                    div_req.divisor  = e_width;
                    state_next       = S_RELX;
                end else if (ram_rd_en) begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_idx_reg[rth_pkg::IDX_W-1:0];
                end else begin
                    res_status_next = rth_pkg::ST_MISS;
                    state_next      = S_OUT;
                end
            end
            S_RELX: begin
                if (div_rsp.done) begin
                    rel_x_next       = div_rsp.quotient[rth_pkg::REL_W-1:0];
                    div_req.start    = 1'b1;
                    div_req.dividend =
                        rth_pkg::DVD_W'({dy_reg, {rth_pkg::FRAC_BITS{1'b0}}});
                    div_req.divisor  = h_reg;
                    state_next       = S_RELY;
                end
            end
            S_RELY: begin
                if (div_rsp.done) begin
                    rel_y_next      = div_rsp.quotient[rth_pkg::REL_W-1:0];
                    res_status_next = rth_pkg::ST_HIT;
                    state_next      = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    if (res_status_reg == rth_pkg::ST_HIT) begin
                        m_idx_next   = rth_pkg::IDX_OUT_W'(hit_idx_reg);
                        m_rel_x_next = rel_x_reg;
                        m_rel_y_next = rel_y_reg;
                    end else begin
                        m_idx_next   = '0;
                        m_rel_x_next = '0;
                        m_rel_y_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            vw_reg       <= PB'(1);
            vh_reg       <= PB'(1);
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            vw_reg       <= vw_next;
            vh_reg       <= vh_next;
            scan_idx_reg <= scan_idx_next;
            cmp_vld_reg  <= cmp_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg    <= cmp_idx_next;
        fx_reg         <= fx_next;
        fy_reg         <= fy_next;
        qy_reg         <= qy_next;
        r_reg          <= r_next;
        dy_reg         <= dy_next;
        h_reg          <= h_next;
        hit_idx_reg    <= hit_idx_next;
        rel_x_reg      <= rel_x_next;
        rel_y_reg      <= rel_y_next;
        res_status_reg <= res_status_next;
        m_status_reg   <= m_status_next;
        m_idx_reg      <= m_idx_next;
        m_rel_x_reg    <= m_rel_x_next;
        m_rel_y_reg    <= m_rel_y_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = rth_pkg::M_TDATA_W'({m_rel_y_reg, m_rel_x_reg, m_idx_reg});

    // ---------------------------------------------------------------
    rth_ram #(
        .WIDTH (rth_pkg::ENTRY_W),
        .DEPTH (rth_pkg::MAX_RECTS)
    ) u_rect_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg[rth_pkg::IDX_W-1:0]),
        .wr_data ({in_height, in_width, in_top, in_left}),
        .rd_en   (ram_rd_en),
        .rd_addr (scan_idx_reg[rth_pkg::IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    rth_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= rth_pkg::CNT_W'(rth_pkg::MAX_RECTS))
        else $error("table count above capacity");

    a_add_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (s_tuser == rth_pkg::MODE_ADD) &&
        (count_reg < rth_pkg::CNT_W'(rth_pkg::MAX_RECTS))
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("add beat did not advance the table count");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_DIVX) || (state_reg == S_DIVY) ||
                         (state_reg == S_RELX) || (state_reg == S_RELY))
        else $error("divider finished outside a divide step");

    a_hit_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && (m_status_reg == rth_pkg::ST_HIT) |-> m_idx_reg < count_reg)
        else $error("hit index beyond stored rectangles");

    a_nohit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && (m_status_reg != rth_pkg::ST_HIT)
        |-> (m_idx_reg == '0) && (m_rel_x_reg == '0) && (m_rel_y_reg == '0))
        else $error("non-hit result carries nonzero position");
`endif

endmodule

/* sim/rect_table_hit_test_tb.sv */
module rect_table_hit_test_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [rth_pkg::Q_W-1:0] left;
        logic [rth_pkg::Q_W-1:0] top;
        logic [rth_pkg::Q_W-1:0] width;
        logic [rth_pkg::Q_W-1:0] height;
    } rect_t;

    typedef struct packed {
        logic [rth_pkg::MODE_W-1:0]     mode;
        logic [rth_pkg::PIXEL_BITS-1:0] px;
        logic [rth_pkg::PIXEL_BITS-1:0] py;
        rect_t                          rect;
    } table_beat_t;

    typedef struct packed {
        rth_pkg::status_t                status;
        logic [rth_pkg::IDX_OUT_W-1:0]   hit_index;
        logic [rth_pkg::REL_W-1:0]       rel_x;
        logic [rth_pkg::REL_W-1:0]       rel_y;
    } hit_result_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [rth_pkg::CFG_ADDR_W-1:0] paddr    = '0;
    logic [rth_pkg::CFG_DATA_W-1:0] pwdata   = '0;
    logic [rth_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [rth_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic [rth_pkg::MODE_W-1:0]     s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [rth_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [rth_pkg::STATUS_W-1:0]   m_tuser;

    // shadow of the block's table and viewport
    rect_t                          rect_table [rth_pkg::MAX_RECTS];
    int unsigned                    rect_total = 0;
    logic [rth_pkg::PIXEL_BITS-1:0] view_w = 1;
    logic [rth_pkg::PIXEL_BITS-1:0] view_h = 1;

    hit_result_t pending_q [$];
    hit_result_t oldest;
    int unsigned error_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        ready_hold     = 1'b0;

    always #4 aclk = ~aclk;

    rect_table_hit_test dut (.*);

    function automatic hit_result_t compute_outcome(input table_beat_t beat);
        hit_result_t                    res;
        rect_t                          e;
        logic [rth_pkg::PIXEL_BITS-1:0] qx;
        logic [rth_pkg::PIXEL_BITS-1:0] qy;
        logic [rth_pkg::PIXEL_BITS-1:0] r;
        logic [rth_pkg::FX_W-1:0]       fx;
        logic [rth_pkg::FX_W-1:0]       fy;
        logic [rth_pkg::FX_W-1:0]       dx;
        logic [rth_pkg::FX_W-1:0]       dy;
        logic [rth_pkg::Q_W:0]          x_end;
        logic [rth_pkg::Q_W:0]          y_end;
        res.status    = rth_pkg::ST_MISS;
        res.hit_index = '0;
        res.rel_x     = '0;
        res.rel_y     = '0;
        if (beat.mode == rth_pkg::MODE_ADD) begin
            if (rect_total >= rth_pkg::MAX_RECTS) begin
                res.status = rth_pkg::ST_FULL;
            end else begin
                rect_table[rect_total] = beat.rect;
                rect_total++;
                res.status = rth_pkg::ST_ADDED;
            end
            return res;
        end
        if (view_h > view_w) begin
            // portrait: rotate, a point right of the viewport lands at negative y
            if (beat.px > view_w) return res;
            qx = beat.py;
            qy = view_w - beat.px;
            r  = view_w;
        end else begin
            qx = beat.px;
            qy = beat.py;
            r  = view_h;
        end
        if (r == 0) return res;
        fx = {qx, {rth_pkg::FRAC_BITS{1'b0}}} / r;
        fy = {qy, {rth_pkg::FRAC_BITS{1'b0}}} / r;
        for (int i = 0; i < rect_total; i++) begin
            e = rect_table[i];
            if (e.width == 0 || e.height == 0) continue;
            x_end = {1'b0, e.left} + e.width;
            y_end = {1'b0, e.top} + e.height;
            if (fx >= e.left && fx < x_end && fy >= e.top && fy < y_end) begin
                dx = fx - e.left;
                dy = fy - e.top;
                res.status    = rth_pkg::ST_HIT;
                res.hit_index = rth_pkg::IDX_OUT_W'(i);
                res.rel_x     = rth_pkg::REL_W'(
                    {dx[rth_pkg::Q_W-1:0], {rth_pkg::FRAC_BITS{1'b0}}} / e.width);
                res.rel_y     = rth_pkg::REL_W'(
                    {dy[rth_pkg::Q_W-1:0], {rth_pkg::FRAC_BITS{1'b0}}} / e.height);
                return res;
            end
        end
        return res;
    endfunction

    function automatic rect_t random_rect();
        rect_t r;
        if ($urandom_range(7) == 0) begin
            r = {$urandom, $urandom};
        end else begin
            r.left   = rth_pkg::Q_W'($urandom_range(16'h1800));
            r.top    = rth_pkg::Q_W'($urandom_range(16'h1800));
            r.width  = rth_pkg::Q_W'($urandom_range(16'h1000, 16'h80));
            r.height = rth_pkg::Q_W'($urandom_range(16'h1000, 16'h80));
        end
        return r;
    endfunction

    function automatic table_beat_t add_beat(input rect_t r);
        table_beat_t beat;
        beat.mode = rth_pkg::MODE_ADD;
        beat.px   = rth_pkg::PIXEL_BITS'($urandom);
        beat.py   = rth_pkg::PIXEL_BITS'($urandom);
        beat.rect = r;
        return beat;
    endfunction

    function automatic table_beat_t query_beat(input logic [rth_pkg::PIXEL_BITS-1:0] x, y);
        table_beat_t beat;
        beat.mode = rth_pkg::MODE_QUERY;
        beat.px   = x;
        beat.py   = y;
        beat.rect = {$urandom, $urandom};
        return beat;
    endfunction

    // mostly on-screen points, some anywhere in the pixel range
    function automatic table_beat_t random_query();
        if ($urandom_range(4) == 0) begin
            return query_beat(rth_pkg::PIXEL_BITS'($urandom_range(4095)),
                              rth_pkg::PIXEL_BITS'($urandom_range(4095)));
        end
        return query_beat(rth_pkg::PIXEL_BITS'($urandom_range(view_w)),
                          rth_pkg::PIXEL_BITS'($urandom_range(view_h)));
    endfunction

    task automatic send_beat(input table_beat_t beat);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        pending_q.push_back(compute_outcome(beat));
        s_tvalid <= 1'b1;
        s_tuser  <= beat.mode;
        s_tdata  <= {beat.rect.height, beat.rect.width, beat.rect.top, beat.rect.left,
                     beat.py, beat.px};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
    endtask

    // back-to-back transfers keep psel high; set_viewport lowers it at the end
    task automatic apb_access(input logic is_write,
                              input logic [rth_pkg::CFG_IDX_W-1:0] idx,
                              input logic [rth_pkg::PIXEL_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= rth_pkg::CFG_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (!is_write && prdata !== rth_pkg::CFG_DATA_W'(value)) begin
            $error("%s: expected %0d, got %0d",
                   (idx == rth_pkg::REG_VIEW_WIDTH) ? "view_width" : "view_height",
                   value, prdata);
            error_count++;
        end
    endtask

    task automatic set_viewport(input logic [rth_pkg::PIXEL_BITS-1:0] w, h);
        drain_results();
        apb_access(1'b1, rth_pkg::REG_VIEW_WIDTH, w);
        apb_access(1'b1, rth_pkg::REG_VIEW_HEIGHT, h);
        view_w = w;
        view_h = h;
        apb_access(1'b0, rth_pkg::REG_VIEW_WIDTH, w);
        apb_access(1'b0, rth_pkg::REG_VIEW_HEIGHT, h);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic test_empty_table();
        send_beat(query_beat(0, 0));
        send_beat(query_beat(4095, 4095));
    endtask

    task automatic test_directed_rects();
        set_viewport(1000, 800);
        // zero-width and zero-height entries sit in front and must be skipped
        send_beat(add_beat('{16'h0000, 16'h0000, 16'h0000, 16'h1000}));
        send_beat(add_beat('{16'h0000, 16'h0000, 16'h1000, 16'h0000}));
        send_beat(add_beat('{16'h0000, 16'h0000, 16'h0800, 16'h0800}));
        send_beat(add_beat('{16'h0800, 16'h0400, 16'h0400, 16'h0C00}));
        // far edges past 0xFFFF
        send_beat(add_beat('{16'hF000, 16'hF000, 16'hFFFF, 16'hFFFF}));
        send_beat(add_beat('{16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001}));
        send_beat(add_beat('{16'h1000, 16'h0000, 16'h3000, 16'h1000}));
        send_beat(query_beat(0, 0));
        send_beat(query_beat(195, 100));
        send_beat(query_beat(500, 400));
        send_beat(query_beat(4095, 4095));
    endtask

    task automatic test_extreme_viewports();
        // short side of one pixel scales the point past 16 bits
        set_viewport(4095, 1);
        send_beat(query_beat(15, 15));
        send_beat(query_beat(16, 16));
        send_beat(query_beat(31, 31));
        set_viewport(480, 640);
        send_beat(query_beat(481, 0));
        send_beat(query_beat(480, 640));
        send_beat(query_beat(0, 0));
        set_viewport(1, 4095);
        send_beat(query_beat(2, 5));
        send_beat(query_beat(0, 4095));
        // zero short side, portrait and landscape
        set_viewport(0, 5);
        send_beat(query_beat(0, 3));
        set_viewport(5, 0);
        send_beat(query_beat(3, 3));
    endtask

    task automatic test_fill_table();
        while (rect_total < rth_pkg::MAX_RECTS) send_beat(add_beat(random_rect()));
        repeat (2) send_beat(add_beat(random_rect()));
    endtask

    task automatic test_output_stall();
        set_viewport(1000, 800);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                ready_hold <= 1'b1;
                repeat (400) @(posedge aclk);
                ready_hold <= 1'b0;
            end
        join_none
        repeat (12) send_beat(random_query());
    endtask

    task automatic test_random_mix();
        logic [rth_pkg::PIXEL_BITS-1:0] widths  [6] = '{4095, 4095, 1, 640, 480, 800};
        logic [rth_pkg::PIXEL_BITS-1:0] heights [6] = '{4095, 1, 4095, 480, 640, 800};
        int unsigned                    idle_pct  [4] = '{0, 69, 0, 6};
        int unsigned                    stall_pct [4] = '{0, 0, 69, 6};
        for (int c = 0; c < 8; c++) begin
            if (c < 6) begin
                set_viewport(widths[c], heights[c]);
            end else begin
                set_viewport(rth_pkg::PIXEL_BITS'($urandom_range(4095, 1)),
                             rth_pkg::PIXEL_BITS'($urandom_range(4095, 1)));
            end
            for (int p = 0; p < 4; p++) begin
                send_idle_pct  = idle_pct[p];
                recv_stall_pct = stall_pct[p];
                repeat (50) begin
                    if ($urandom_range(9) == 0) begin
                        send_beat(add_beat(random_rect()));
                    end else begin
                        send_beat(random_query());
                    end
                end
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn || ready_hold) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                $error("result beat with nothing outstanding: status %0d", m_tuser);
                error_count++;
            end else begin
                oldest = pending_q.pop_front();
                if (m_tuser !== oldest.status) begin
                    $error("status: expected %0d, got %0d", oldest.status, m_tuser);
                    error_count++;
                end
                if (m_tdata[rth_pkg::IDX_OUT_W-1:0] !== oldest.hit_index) begin
                    $error("hit_index: expected %0d, got %0d", oldest.hit_index,
                           m_tdata[rth_pkg::IDX_OUT_W-1:0]);
                    error_count++;
                end
                if (m_tdata[rth_pkg::IDX_OUT_W +: rth_pkg::REL_W] !== oldest.rel_x) begin
                    $error("rel_x: expected %0d, got %0d", oldest.rel_x,
                           m_tdata[rth_pkg::IDX_OUT_W +: rth_pkg::REL_W]);
                    error_count++;
                end
                if (m_tdata[rth_pkg::IDX_OUT_W+rth_pkg::REL_W +: rth_pkg::REL_W]
                        !== oldest.rel_y) begin
                    $error("rel_y: expected %0d, got %0d", oldest.rel_y,
                           m_tdata[rth_pkg::IDX_OUT_W+rth_pkg::REL_W +: rth_pkg::REL_W]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_table();
        test_directed_rects();
        test_extreme_viewports();
        test_fill_table();
        test_output_stall();
        test_random_mix();
        drain_results();
        // catch any stray beats after the last expected one
        repeat (200) @(posedge aclk);
        if (error_count == 0 && pending_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
